### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the attenuation stepper RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("next-cycle check failed");

`endif

### rtl/ras_pkg.sv
// ---------------------------------------------------------------------------
// ras_pkg
// Types, constants and helper functions of the ALC attenuation stepper.
// ---------------------------------------------------------------------------
`default_nettype none

package ras_pkg;

    localparam int POW_W   = 12;   // power fields, tenths of dB
    localparam int DB_W    = 8;    // whole-dB config fields
    localparam int ATT_W   = 8;    // attenuation counts
    localparam int EDGE_W  = 14;   // window edges, tenths of dB
    localparam int SUM_W   = 10;   // start + count, whole dB
    localparam int IDX_W   = 3;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 32;

    localparam logic [ATT_W-1:0] ATT_MAX  = 8'd255;
    localparam logic [ATT_W-1:0] LINK_MAX = 8'd255;
    localparam logic [ATT_W-1:0] LINK_OFS = 8'd10;

    localparam logic signed [DB_W-1:0] DET_TARGET_RST = -8'sd5;
    localparam logic [DB_W-1:0]        TABLE_COUNT_RST = 8'd64;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_DL_TARGET = 3'd0,
        REG_UL_TARGET = 3'd1,
        REG_UL_LIMIT  = 3'd2,
        REG_DET_TGT   = 3'd3,
        REG_DL_START  = 3'd4,
        REG_DL_COUNT  = 3'd5,
        REG_UL_START  = 3'd6,
        REG_UL_COUNT  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [POW_W-1:0] dl_target_tenths;
        logic signed [POW_W-1:0] ul_target_tenths;
        logic signed [POW_W-1:0] ul_limit_tenths;
        logic signed [DB_W-1:0]  det_target_db;
        logic signed [DB_W-1:0]  dl_table_start;
        logic [DB_W-1:0]         dl_table_count;
        logic signed [DB_W-1:0]  ul_table_start;
        logic [DB_W-1:0]         ul_table_count;
    } cfg_t;

    typedef struct packed {
        logic signed [POW_W-1:0] det_power_tenths;
        logic signed [POW_W-1:0] dl_power_tenths;
        logic signed [POW_W-1:0] ul_power_tenths;
        logic                    det_headroom;
        logic                    dl_headroom;
        logic                    ul_headroom;
        logic                    dl_lock;
        logic                    ul_lock;
        logic                    normal_mode;
    } item_t;

    typedef struct packed {
        logic [ATT_W-1:0] det_att;
        logic [ATT_W-1:0] dl_att;
        logic [ATT_W-1:0] ul_att;
        logic [ATT_W-1:0] ul_link;
    } state_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] up;
        logic signed [EDGE_W-1:0] lo;
    } win_t;

    // Sign-extend a whole-dB sum and scale it to tenths (x*8 + x*2)
    function automatic logic signed [EDGE_W-1:0] times10(input logic signed [SUM_W-1:0] v);
        logic signed [EDGE_W-1:0] w;
        w = {{(EDGE_W-SUM_W){v[SUM_W-1]}}, v};
        return (w <<< 3) + (w <<< 1);
    endfunction

    // Sign-extend a power / target in tenths to edge width
    function automatic logic signed [EDGE_W-1:0] ext_pow(input logic signed [POW_W-1:0] v);
        return {{(EDGE_W-POW_W){v[POW_W-1]}}, v};
    endfunction

    // One-dB step: up at or above the upper edge, down at or below the lower
    function automatic logic [ATT_W-1:0] step_att(
        input logic [ATT_W-1:0]        att,
        input logic signed [POW_W-1:0] pow,
        input win_t                    win,
        input logic                    headroom
    );
        logic signed [EDGE_W-1:0] p;
        logic signed [EDGE_W-1:0] up;
        logic signed [EDGE_W-1:0] lo;
        logic [ATT_W-1:0]         res;
        p   = ext_pow(pow);
        up  = win.up;
        lo  = win.lo;
        res = att;
        if (p >= up) begin
            if (headroom && (att < ATT_MAX)) begin
                res = att + 8'd1;
            end
        end else if (p <= lo) begin
            if (att != '0) begin
                res = att - 8'd1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ras_window.sv
// ---------------------------------------------------------------------------
// ras_window
// +-1 dB window around a target, clamped to a power table's range.
// ---------------------------------------------------------------------------
`default_nettype none

module ras_window (
    input  wire logic signed [ras_pkg::POW_W-1:0] target,
    input  wire logic signed [ras_pkg::DB_W-1:0]  start,
    input  wire logic [ras_pkg::DB_W-1:0]         count,
    output ras_pkg::win_t                         win
);

    logic signed [ras_pkg::SUM_W-1:0]  start_s;
    logic signed [ras_pkg::SUM_W-1:0]  top_s;
    logic signed [ras_pkg::EDGE_W-1:0] base_t;
    logic signed [ras_pkg::EDGE_W-1:0] top_t;
    logic signed [ras_pkg::EDGE_W-1:0] tgt_t;
    logic signed [ras_pkg::EDGE_W-1:0] up0;
    logic signed [ras_pkg::EDGE_W-1:0] lo0;

    // table edges in tenths
    assign start_s = {{(ras_pkg::SUM_W-ras_pkg::DB_W){start[ras_pkg::DB_W-1]}}, start};
    assign top_s   = start_s + $signed({{(ras_pkg::SUM_W-ras_pkg::DB_W){1'b0}}, count});
    assign base_t  = ras_pkg::times10(start_s);
    assign top_t   = ras_pkg::times10(top_s);
    assign tgt_t   = ras_pkg::ext_pow(target);
    assign up0     = tgt_t + 14'sd10;
    assign lo0     = tgt_t - 14'sd10;

    // clamp: window above table first, then below table
    always_comb
    begin
        if (up0 > top_t)
        begin
            win.up = top_t - 14'sd10;
            win.lo = top_t - 14'sd30;
        end
        else if (lo0 < base_t)
        begin
            win.lo = base_t + 14'sd10;
            win.up = base_t + 14'sd30;
        end
        else
        begin
            win.up = up0;
            win.lo = lo0;
        end
    end

endmodule

`default_nettype wire

### rtl/ras_update.sv
// ---------------------------------------------------------------------------
// ras_update
// Next attenuation state for one tick: detector, downlink, link, uplink.
// ---------------------------------------------------------------------------
`default_nettype none

module ras_update (
    input  wire ras_pkg::item_t  item,
    input  wire ras_pkg::cfg_t   cfg,
    input  wire ras_pkg::state_t cur,
    output ras_pkg::state_t      nxt
);

    ras_pkg::win_t det_win;
    ras_pkg::win_t dl_win;
    ras_pkg::win_t ul_win;

    logic signed [ras_pkg::EDGE_W-1:0] det_t;
    logic signed [ras_pkg::POW_W-1:0]  ul_tgt;
    logic [ras_pkg::ATT_W-1:0]         det_new;
    logic [ras_pkg::ATT_W-1:0]         dl_new;
    logic [ras_pkg::ATT_W-1:0]         extra;
    logic [ras_pkg::ATT_W:0]           link_sum;

    // detector window: plain +-1 dB, no table clamp
    assign det_t = ras_pkg::times10(
        {{(ras_pkg::SUM_W-ras_pkg::DB_W){cfg.det_target_db[ras_pkg::DB_W-1]}},
         cfg.det_target_db});
    assign det_win.up = det_t + 14'sd10;
    assign det_win.lo = det_t - 14'sd10;

    ras_window u_dl_win (
        .target (cfg.dl_target_tenths),
        .start  (cfg.dl_table_start),
        .count  (cfg.dl_table_count),
        .win    (dl_win)
    );

    // uplink target capped by the output limit
    assign ul_tgt = ($signed(cfg.ul_target_tenths) > $signed(cfg.ul_limit_tenths)) ?
                    cfg.ul_limit_tenths : cfg.ul_target_tenths;

    ras_window u_ul_win (
        .target (ul_tgt),
        .start  (cfg.ul_table_start),
        .count  (cfg.ul_table_count),
        .win    (ul_win)
    );

    // detector and downlink loops, held by dl_lock
    assign det_new = item.dl_lock ? cur.det_att :
        ras_pkg::step_att(cur.det_att, item.det_power_tenths, det_win, item.det_headroom);
    assign dl_new  = item.dl_lock ? cur.dl_att :
        ras_pkg::step_att(cur.dl_att, item.dl_power_tenths, dl_win, item.dl_headroom);

    // link: downlink att plus detector att above 10 dB, saturated
    assign extra    = (det_new >= ras_pkg::LINK_OFS) ? (det_new - ras_pkg::LINK_OFS) : '0;
    assign link_sum = {1'b0, dl_new} + {1'b0, extra};

    always_comb
    begin
        nxt.det_att = det_new;
        nxt.dl_att  = dl_new;
        if (!item.normal_mode)
        begin
            nxt.ul_link = '0;
        end
        else if (link_sum[ras_pkg::ATT_W])
        begin
            nxt.ul_link = ras_pkg::LINK_MAX;
        end
        else
        begin
            nxt.ul_link = link_sum[ras_pkg::ATT_W-1:0];
        end
        nxt.ul_att = item.ul_lock ? cur.ul_att :
            ras_pkg::step_att(cur.ul_att, item.ul_power_tenths, ul_win, item.ul_headroom);
    end

endmodule

`default_nettype wire

### rtl/rf_alc_attenuation_stepper.sv
// ---------------------------------------------------------------------------
// rf_alc_attenuation_stepper
// Automatic level control tick for detector, downlink and uplink attenuators.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one measurement word per ALC tick (three powers in tenths
//   of dB plus headroom, lock and normal-mode flags). m_axis returns one word
//   per tick with the updated detector, downlink, uplink attenuation and the
//   uplink link value.
//   cfg_* writes the eight setpoint/table registers; it is always ready and
//   must only be used while no tick is in flight.
//   A word accepted into the input register is evaluated and lands in the
//   result register once that register is free; m_axis_tvalid rises with it.
//   Throughput: one word per cycle while m_axis_tready is high; a single pass
//   through the window compare and +-1 step logic, input to result register.
//   The result register is also the attenuation state, so it only advances
//   when the held result is taken. While m_axis_tready is low, the input
//   register still takes one word, then s_axis_tready drops.
//   Reset: all attenuations and the link value clear to 0, registers return
//   to their defaults, both channels empty.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rf_alc_attenuation_stepper (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // config write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ras_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [ras_pkg::POW_W-1:0]       cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [11:0] det_power_tenths, [23:12] dl_power_tenths, [35:24] ul_power_tenths,
    // [36] det_headroom, [37] dl_headroom, [38] ul_headroom, [39] dl_lock,
    // [40] ul_lock, [41] normal_mode, [47:42] zero
    input  wire logic [ras_pkg::IN_W-1:0]        s_axis_tdata,
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] det_att_out, [15:8] dl_att_out, [23:16] ul_att_out, [31:24] ul_link_out
    output logic [ras_pkg::OUT_W-1:0]            m_axis_tdata
);

    ras_pkg::cfg_t   cfg_reg;
    ras_pkg::item_t  in_reg;
    ras_pkg::item_t  in_next;
    ras_pkg::state_t state_reg;
    ras_pkg::state_t state_next;
    logic            in_valid_reg;
    logic            out_valid_reg;
    logic            out_free;
    logic            advance;
    logic            s_accept;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dl_target_tenths <= '0;
            cfg_reg.ul_target_tenths <= '0;
            cfg_reg.ul_limit_tenths  <= '0;
            cfg_reg.det_target_db    <= ras_pkg::DET_TARGET_RST;
            cfg_reg.dl_table_start   <= '0;
            cfg_reg.dl_table_count   <= ras_pkg::TABLE_COUNT_RST;
            cfg_reg.ul_table_start   <= '0;
            cfg_reg.ul_table_count   <= ras_pkg::TABLE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ras_pkg::reg_idx_t'(cfg_index))
                ras_pkg::REG_DL_TARGET: cfg_reg.dl_target_tenths <= cfg_data;
                ras_pkg::REG_UL_TARGET: cfg_reg.ul_target_tenths <= cfg_data;
                ras_pkg::REG_UL_LIMIT:  cfg_reg.ul_limit_tenths  <= cfg_data;
                ras_pkg::REG_DET_TGT:   cfg_reg.det_target_db    <= cfg_data[ras_pkg::DB_W-1:0];
                ras_pkg::REG_DL_START:  cfg_reg.dl_table_start   <= cfg_data[ras_pkg::DB_W-1:0];
                ras_pkg::REG_DL_COUNT:  cfg_reg.dl_table_count   <= cfg_data[ras_pkg::DB_W-1:0];
                ras_pkg::REG_UL_START:  cfg_reg.ul_table_start   <= cfg_data[ras_pkg::DB_W-1:0];
                ras_pkg::REG_UL_COUNT:  cfg_reg.ul_table_count   <= cfg_data[ras_pkg::DB_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: input stage drains into the result register when it is free
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // unpack the input word
    assign in_next.det_power_tenths = s_axis_tdata[11:0];
    assign in_next.dl_power_tenths  = s_axis_tdata[23:12];
    assign in_next.ul_power_tenths  = s_axis_tdata[35:24];
    assign in_next.det_headroom     = s_axis_tdata[36];
    assign in_next.dl_headroom      = s_axis_tdata[37];
    assign in_next.ul_headroom      = s_axis_tdata[38];
    assign in_next.dl_lock          = s_axis_tdata[39];
    assign in_next.ul_lock          = s_axis_tdata[40];
    assign in_next.normal_mode      = s_axis_tdata[41];

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_reg <= in_next;
        end
    end

    ras_update u_update (
        .item (in_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // attenuation state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {state_reg.ul_link, state_reg.ul_att,
                            state_reg.dl_att, state_reg.det_att};

    // checks
    `ASSERT_NEXT(a_state_hold, clk, rst_n, !advance, $stable(state_reg))
    `ASSERT_NEXT(a_dl_lock_hold, clk, rst_n, advance && in_reg.dl_lock, (state_reg.det_att == $past(state_reg.det_att)) && (state_reg.dl_att == $past(state_reg.dl_att)))
    `ASSERT_NEXT(a_link_off, clk, rst_n, advance && !in_reg.normal_mode, state_reg.ul_link == '0)
    `ASSERT_SAME(a_result_taken, clk, rst_n, advance, !out_valid_reg || m_axis_tready)

endmodule

`default_nettype wire

### dv/alc_level_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alc_level_checker
// Watches the config, input and result channels of the ALC attenuation
// stepper, keeps its own copy of the registers and attenuation levels,
// predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module alc_level_checker
    import ras_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [POW_W-1:0] cfg_data,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    // [11:0] det power, [23:12] dl power, [35:24] ul power, [36] det headroom,
    // [37] dl headroom, [38] ul headroom, [39] dl lock, [40] ul lock,
    // [41] normal mode, [47:42] zero
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [7:0] det att, [15:8] dl att, [23:16] ul att, [31:24] ul link
    input  wire logic [OUT_W-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen
);

    // flag bit positions in the input word
    localparam int BIT_DET_HR = 36;
    localparam int BIT_DL_HR  = 37;
    localparam int BIT_UL_HR  = 38;
    localparam int BIT_DL_LK  = 39;
    localparam int BIT_UL_LK  = 40;
    localparam int BIT_NORMAL = 41;
    localparam int MAX_PRINTS = 100;

    cfg_t   regs;
    state_t levels;
    state_t oldest;
    state_t level_queue[$];

    initial
    begin
        fail_count   = 0;
        results_seen = 0;
        pending      = 0;
    end

    // one line per mismatch, printing capped so a dead block stays readable
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_PRINTS)
        begin
            $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        fail_count++;
    endtask

    // +-1 dB step against a window in tenths of dB
    function automatic logic [ATT_W-1:0] nudge_att(input logic [ATT_W-1:0] att,
                                                   input int pow, input int up,
                                                   input int lo, input logic hr);
        logic [ATT_W-1:0] res;
        res = att;
        if (pow >= up)
        begin
            if (hr && (att < ATT_MAX))
            begin
                res = att + 8'd1;
            end
        end
        else if (pow <= lo)
        begin
            if (att != '0)
            begin
                res = att - 8'd1;
            end
        end
        return res;
    endfunction

    // window of +-1 dB around target, pulled inside the power table
    function automatic logic [ATT_W-1:0] windowed_nudge(input logic [ATT_W-1:0] att,
                                                        input int pow, input int target,
                                                        input int start, input int count,
                                                        input logic hr);
        int up;
        int lo;
        up = target + 10;
        lo = target - 10;
        if (up > (start + count) * 10)
        begin
            up = (start + count - 1) * 10;
            lo = up - 20;
        end
        else if (lo < start * 10)
        begin
            lo = (start + 1) * 10;
            up = lo + 20;
        end
        return nudge_att(att, pow, up, lo, hr);
    endfunction

    // levels after one tick
    function automatic state_t next_levels(input state_t cur, input logic [IN_W-1:0] w);
        state_t nxt;
        int     det_pow;
        int     dl_pow;
        int     ul_pow;
        int     det_t;
        int     ul_t;
        int     lim;
        int     extra;
        int     total;
        nxt     = cur;
        det_pow = $signed(w[11:0]);
        dl_pow  = $signed(w[23:12]);
        ul_pow  = $signed(w[35:24]);

        if (!w[BIT_DL_LK])
        begin
            det_t       = $signed(regs.det_target_db);
            det_t       = det_t * 10;
            nxt.det_att = nudge_att(cur.det_att, det_pow, det_t + 10, det_t - 10,
                                    w[BIT_DET_HR]);
            nxt.dl_att  = windowed_nudge(cur.dl_att, dl_pow, $signed(regs.dl_target_tenths),
                                         $signed(regs.dl_table_start),
                                         int'(regs.dl_table_count), w[BIT_DL_HR]);
        end

        // link is recomputed every tick, locked or not
        if (w[BIT_NORMAL])
        begin
            extra       = (nxt.det_att >= 8'd10) ? int'(nxt.det_att) - 10 : 0;
            total       = int'(nxt.dl_att) + extra;
            nxt.ul_link = (total > 255) ? 8'd255 : total[ATT_W-1:0];
        end
        else
        begin
            nxt.ul_link = '0;
        end

        if (!w[BIT_UL_LK])
        begin
            ul_t = $signed(regs.ul_target_tenths);
            lim  = $signed(regs.ul_limit_tenths);
            if (ul_t > lim)
            begin
                ul_t = lim;
            end
            nxt.ul_att = windowed_nudge(cur.ul_att, ul_pow, ul_t,
                                        $signed(regs.ul_table_start),
                                        int'(regs.ul_table_count), w[BIT_UL_HR]);
        end
        return nxt;
    endfunction

    // register write as the block sees it
    task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [POW_W-1:0] value);
        case (reg_idx_t'(idx))
            REG_DL_TARGET: regs.dl_target_tenths = value;
            REG_UL_TARGET: regs.ul_target_tenths = value;
            REG_UL_LIMIT:  regs.ul_limit_tenths  = value;
            REG_DET_TGT:   regs.det_target_db    = value[DB_W-1:0];
            REG_DL_START:  regs.dl_table_start   = value[DB_W-1:0];
            REG_DL_COUNT:  regs.dl_table_count   = value[DB_W-1:0];
            REG_UL_START:  regs.ul_table_start   = value[DB_W-1:0];
            REG_UL_COUNT:  regs.ul_table_count   = value[DB_W-1:0];
            default: ;
        endcase
    endtask

    // results are taken before new words, since a result never leaves in the cycle its word is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.dl_target_tenths = '0;
            regs.ul_target_tenths = '0;
            regs.ul_limit_tenths  = '0;
            regs.det_target_db    = DET_TARGET_RST;
            regs.dl_table_start   = '0;
            regs.dl_table_count   = TABLE_COUNT_RST;
            regs.ul_table_start   = '0;
            regs.ul_table_count   = TABLE_COUNT_RST;
            levels                = '0;
            level_queue.delete();
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (level_queue.size() == 0)
                begin
                    report_mismatch("result word with nothing expected", m_axis_tdata, 0);
                end
                else
                begin
                    oldest = level_queue.pop_front();
                    if (m_axis_tdata[7:0] !== oldest.det_att)
                        report_mismatch("det_att_out", m_axis_tdata[7:0], oldest.det_att);
                    if (m_axis_tdata[15:8] !== oldest.dl_att)
                        report_mismatch("dl_att_out", m_axis_tdata[15:8], oldest.dl_att);
                    if (m_axis_tdata[23:16] !== oldest.ul_att)
                        report_mismatch("ul_att_out", m_axis_tdata[23:16], oldest.ul_att);
                    if (m_axis_tdata[31:24] !== oldest.ul_link)
                        report_mismatch("ul_link_out", m_axis_tdata[31:24], oldest.ul_link);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                apply_write(cfg_index, cfg_data);
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                levels = next_levels(levels, s_axis_tdata);
                level_queue.push_back(levels);
            end

            pending <= level_queue.size();
        end
    end

endmodule

### dv/rf_alc_attenuation_stepper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_alc_attenuation_stepper_test
// Drives measurement words and register settings into the ALC stepper with
// random gaps and output stalls; the level checker predicts and compares
// every result word. Covers ramps to both saturation limits, window edges,
// table clamping, empty tables, locks and linking.
// ----------------------------------------------------------------------------
module rf_alc_attenuation_stepper_test;
    import ras_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_PHASES     = 7;

    // flag field of the input word, bits [41:36]
    localparam logic [5:0] F_DET_HR = 6'b000001;
    localparam logic [5:0] F_DL_HR  = 6'b000010;
    localparam logic [5:0] F_UL_HR  = 6'b000100;
    localparam logic [5:0] F_DL_LK  = 6'b001000;
    localparam logic [5:0] F_UL_LK  = 6'b010000;
    localparam logic [5:0] F_NORMAL = 6'b100000;
    localparam logic [5:0] F_ALL_HR = F_DET_HR | F_DL_HR | F_UL_HR;

    typedef enum int {
        SET_DEFAULT,
        SET_MAX,
        SET_MIN,
        SET_SPEC_EDGES,
        SET_RANDOM,
        SET_EMPTY
    } setting_kind_t;

    typedef enum int {
        MIX_UP,
        MIX_DOWN,
        MIX_NEAR,
        MIX_ANY
    } word_mix_t;

    setting_kind_t plan_setting [NUM_PHASES] = '{SET_DEFAULT, SET_DEFAULT, SET_RANDOM,
                                                 SET_MAX, SET_MIN, SET_EMPTY,
                                                 SET_SPEC_EDGES};
    word_mix_t     plan_mix     [NUM_PHASES] = '{MIX_UP, MIX_DOWN, MIX_NEAR, MIX_ANY,
                                                 MIX_NEAR, MIX_NEAR, MIX_ANY};
    int            plan_count   [NUM_PHASES] = '{350, 300, 160, 160, 160, 160, 160};

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index     = '0;
    logic [POW_W-1:0] cfg_data      = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   results_seen;
    int   items_sent       = 0;
    int   settings_written = 0;
    int   idle_cycles      = 0;
    int   stall_left       = 0;
    logic quiet            = 1'b0;
    cfg_t setting;

    rf_alc_attenuation_stepper DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    alc_level_checker level_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // gap lengths: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    function automatic logic [POW_W-1:0] fit12(input int v);
        if (v > 2047) return 12'h7FF;
        if (v < -2048) return 12'h800;
        return v[POW_W-1:0];
    endfunction

    function automatic logic [IN_W-1:0] pack_word(input int det, input int dl, input int ul,
                                                  input logic [5:0] flags);
        return {6'b0, flags, fit12(ul), fit12(dl), fit12(det)};
    endfunction

    function automatic cfg_t pick_setting(input setting_kind_t kind);
        cfg_t        c;
        logic [95:0] bits;
        c.dl_target_tenths = '0;
        c.ul_target_tenths = '0;
        c.ul_limit_tenths  = '0;
        c.det_target_db    = DET_TARGET_RST;
        c.dl_table_start   = '0;
        c.dl_table_count   = TABLE_COUNT_RST;
        c.ul_table_start   = '0;
        c.ul_table_count   = TABLE_COUNT_RST;
        bits = {$urandom, $urandom, $urandom};
        case (kind)
            SET_MAX:
            begin
                c.dl_target_tenths = 12'h7FF;
                c.ul_target_tenths = 12'h7FF;
                c.ul_limit_tenths  = 12'h7FF;
                c.det_target_db    = 8'h7F;
                c.dl_table_start   = 8'h7F;
                c.dl_table_count   = 8'hFF;
                c.ul_table_start   = 8'h7F;
                c.ul_table_count   = 8'hFF;
            end
            SET_MIN:
            begin
                c.dl_target_tenths = 12'h800;
                c.ul_target_tenths = 12'h800;
                c.ul_limit_tenths  = 12'h800;
                c.det_target_db    = 8'h80;
                c.dl_table_start   = 8'h80;
                c.dl_table_count   = 8'h00;
                c.ul_table_start   = 8'h80;
                c.ul_table_count   = 8'h00;
            end
            SET_SPEC_EDGES:
            begin
                c.dl_target_tenths = fit12(1270);
                c.ul_target_tenths = fit12(-1280);
                c.ul_limit_tenths  = fit12(1270);
                c.det_target_db    = 8'h80;
                c.dl_table_start   = 8'h80;
                c.dl_table_count   = 8'hFF;
                c.ul_table_start   = 8'h7F;
                c.ul_table_count   = 8'h01;
            end
            SET_RANDOM:
            begin
                c = bits[$bits(cfg_t)-1:0];
            end
            SET_EMPTY:
            begin
                c                  = bits[$bits(cfg_t)-1:0];
                c.dl_target_tenths = fit12(int'($urandom_range(0, 2550)) - 1280);
                c.ul_target_tenths = fit12(int'($urandom_range(0, 2550)) - 1280);
                c.ul_limit_tenths  = fit12(int'($urandom_range(0, 2550)) - 1280);
                c.dl_table_count   = 8'h00;
                c.ul_table_count   = 8'h00;
            end
            default: ;
        endcase
        return c;
    endfunction

    // measurement word for one tick, biased by the phase mix
    function automatic logic [IN_W-1:0] random_word(input word_mix_t mix);
        int         det;
        int         dl;
        int         ul;
        int         ul_t;
        int         lim;
        logic [5:0] flags;
        flags = 6'($urandom);
        det   = $signed(12'($urandom));
        dl    = $signed(12'($urandom));
        ul    = $signed(12'($urandom));
        case (mix)
            MIX_UP:
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    det   = $urandom_range(1200, 2047);
                    dl    = $urandom_range(1200, 2047);
                    ul    = $urandom_range(1200, 2047);
                    flags = F_ALL_HR | (($urandom_range(0, 4) != 0) ? F_NORMAL : 6'b0);
                end
            end
            MIX_DOWN:
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    det   = -int'($urandom_range(1300, 2048));
                    dl    = -int'($urandom_range(1300, 2048));
                    ul    = -int'($urandom_range(1300, 2048));
                    flags = flags & ~(F_DL_LK | F_UL_LK);
                end
            end
            MIX_NEAR:
            begin
                // land on and around the window edges
                ul_t = $signed(setting.ul_target_tenths);
                lim  = $signed(setting.ul_limit_tenths);
                if (ul_t > lim)
                begin
                    ul_t = lim;
                end
                det = $signed(setting.det_target_db);
                det = det * 10 + int'($urandom_range(0, 50)) - 25;
                dl  = $signed(setting.dl_target_tenths);
                dl  = dl + int'($urandom_range(0, 50)) - 25;
                ul  = ul_t + int'($urandom_range(0, 50)) - 25;
                if ($urandom_range(0, 3) != 0)
                begin
                    flags = flags & ~(F_DL_LK | F_UL_LK);
                end
            end
            default: ;
        endcase
        return pack_word(det, dl, ul, flags);
    endfunction

    // valid stays high into the next word when there is no gap
    task automatic send_word(input logic [IN_W-1:0] w);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // all eight registers, junk in the unused upper bits of the 8-bit ones
    task automatic write_setting(input cfg_t c);
        int               r;
        logic [POW_W-1:0] value;
        for (r = 0; r < 8; r++)
        begin
            case (reg_idx_t'(r))
                REG_DL_TARGET: value = c.dl_target_tenths;
                REG_UL_TARGET: value = c.ul_target_tenths;
                REG_UL_LIMIT:  value = c.ul_limit_tenths;
                REG_DET_TGT:   value = {4'($urandom), c.det_target_db};
                REG_DL_START:  value = {4'($urandom), c.dl_table_start};
                REG_DL_COUNT:  value = {4'($urandom), c.dl_table_count};
                REG_UL_START:  value = {4'($urandom), c.ul_table_start};
                REG_UL_COUNT:  value = {4'($urandom), c.ul_table_count};
                default:       value = '0;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= reg_idx_t'(r);
            cfg_data  <= value;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        setting = c;
        settings_written++;
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!quiet && ($urandom_range(0, 3) == 0))
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_len();
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog: cycles in which no word moves on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no word moved for %0d cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int n;
        setting = pick_setting(SET_DEFAULT);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks on the reset registers:
        // det window [-60,-40], dl and ul windows clamped to [10,30]
        send_word(pack_word(0, 0, 0, 6'b0));
        send_word(pack_word(-40, 30, 30, F_ALL_HR | F_NORMAL));
        send_word(pack_word(-41, 29, 29, F_ALL_HR | F_NORMAL));
        send_word(pack_word(-60, 10, 10, F_NORMAL));
        send_word(pack_word(-59, 11, 11, F_ALL_HR));
        send_word(pack_word(2047, 2047, 2047, 6'b0));
        repeat (6) send_word(pack_word(2047, 2047, 2047, F_ALL_HR | F_NORMAL));
        send_word(pack_word(2047, 2047, 2047, F_ALL_HR | F_DL_LK | F_NORMAL));
        send_word(pack_word(2047, 2047, 2047, F_ALL_HR | F_UL_LK | F_NORMAL));
        send_word(pack_word(-2048, -2048, -2048, F_DL_LK | F_UL_LK | F_NORMAL));
        send_word(pack_word(-2048, -2048, -2048, F_NORMAL));
        send_word(pack_word(-2048, -2048, -2048, 6'b0));
        send_word(pack_word(1270, 1270, 1270, F_ALL_HR | F_NORMAL));
        send_word(pack_word(-1280, -1280, -1280, F_ALL_HR));
        send_word(pack_word(0, 0, 0, F_ALL_HR | F_DL_LK | F_UL_LK));

        // random phases, each on a fresh register setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_setting(pick_setting(plan_setting[p]));
            for (n = 0; n < plan_count[p]; n++)
            begin
                quiet <= ((n % 120) < 25);
                send_word(random_word(plan_mix[p]));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d measurement words over %0d register settings,",
                 items_sent, settings_written);
        $display("with ramps to both attenuation limits; %0d result words checked.",
                 results_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
